// ----- design/fhi_pkg.sv -----
// Package for the fixed Huffman inflate block: phase and status codes, tables.
// Depends on nothing; used by fixed_huffman_inflate_top.
package fhi_pkg;

   typedef enum logic [5:0] {
      PH_HEADER     = 6'b000001,
      PH_LIT        = 6'b000010,
      PH_LEN_EXTRA  = 6'b000100,
      PH_DIST       = 6'b001000,
      PH_DIST_EXTRA = 6'b010000,
      PH_STOPPED    = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUNNING  = 3'd0,
      ST_DONE     = 3'd1,
      ST_BAD_TYPE = 3'd2,
      ST_BAD_LIT  = 3'd3,
      ST_BAD_DIST = 3'd4,
      ST_TOO_FAR  = 3'd5
   } status_type;

   localparam int unsigned LIT_OFFSET  = 48;
   localparam int unsigned LEN_OFFSET  = 88;
   localparam int unsigned END_SYMBOL  = 256;
   localparam int unsigned MAX_LEN_SYM = 285;
   localparam int unsigned MAX_DIST_CODE = 29;

   function automatic logic [8:0] len_base(input logic [4:0] i);
      logic [8:0] r;
      unique case (i)
         5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;    5'd3: r = 9'd6;
         5'd4: r = 9'd7;    5'd5: r = 9'd8;    5'd6: r = 9'd9;    5'd7: r = 9'd10;
         5'd8: r = 9'd11;   5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
         5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
         5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
         5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
         5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
         default: r = 9'd258;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] len_extra(input logic [4:0] i);
      logic [3:0] r;
      if (i < 5'd8 || i >= 5'd28) r = 4'd0;
      else r = 4'(((i - 5'd8) >> 2) + 5'd1);
      return r;
   endfunction

   function automatic logic [15:0] dist_base(input logic [4:0] i);
      logic [15:0] r;
      if (i < 5'd4) r = 16'(i) + 16'd1;
      else r = (16'd1 << ((i >> 1) - 5'd1)) * (16'd2 + 16'(i[0])) + 16'd1;
      return r;
   endfunction

   function automatic logic [3:0] dist_extra(input logic [4:0] i);
      logic [3:0] r;
      if (i < 5'd4) r = 4'd0;
      else r = 4'((i >> 1) - 5'd1);
      return r;
   endfunction

endpackage

// ----- design/fhi_history.sv -----
// History ring memory of the inflate block, one write and one read port.
// Depends on nothing; instantiated by fixed_huffman_inflate_top.
module fhi_history #(
   parameter int unsigned DEPTH = 32768,
   parameter int unsigned AW = 15
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- design/fixed_huffman_inflate_top.sv -----
// Top level of the fixed Huffman inflate block: bit decoder, copy engine,
// result packer. Depends on fhi_pkg and fhi_history.
//
// Input channel req_ takes one compressed byte per beat, bit 0 first.
// Result channel rsp_ gives up to eight decoded bytes per beat with count,
// a run_last flag on the final beat caused by an input byte, and status.
// Every beat carries the status reached after the whole input byte.
// A byte is accepted in the idle state and then decoded bit-serially.
// Its last beat is offered once its last bit is decoded or decode stops.
// A new byte is taken only after the last one is fully decoded, and not
// while the output register still holds a beat waiting for the receiver.
// A match copy runs a read state and a write state for each history byte,
// since the single read port of the history memory is used once per copied byte.
// A beat is sent per eight bytes, and at byte end if bytes remain or on a stop.
// After end of block or an error further bytes are accepted and dropped.
// Reset returns to the header phase; history content is left undefined.
// When the receiver stalls, decode waits on the full output register.
module fixed_huffman_inflate_top #(
   parameter int unsigned WINDOW_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_out_count,
   output logic        rsp_run_last,
   output logic [2:0]  rsp_status
);
   import fhi_pkg::*;

   localparam int unsigned AW = $clog2(WINDOW_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_BYTES - 1);

   typedef enum logic [3:0] {
      SQ_IDLE = 4'b0001,
      SQ_BIT  = 4'b0010,
      SQ_READ = 4'b0100,
      SQ_WRITE = 4'b1000
   } seq_type;

   seq_type    seq_ff, seq_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] bit_ff, bit_in;
   logic [8:0] code_ff, code_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] need_ff, need_in;
   logic [12:0] extra_ff, extra_in;
   logic [8:0] len_ff, len_in;
   logic [15:0] dist_ff, dist_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW:0] fill_ff, fill_in;
   logic [2:0] stat_ff, stat_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0] acnt_ff, acnt_in;
   logic        sent_ff, sent_in;
   logic        ov_ff, ov_in;
   logic [63:0] ob_ff, ob_in;
   logic [3:0]  oc_ff, oc_in;
   logic        ol_ff, ol_in;
   logic [2:0]  os_ff, os_in;

   logic          wr_en;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   fhi_history #(.DEPTH(WINDOW_BYTES), .AW(AW)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(wp_ff), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_ready     = (seq_ff == SQ_IDLE) && !ov_ff;
   assign rsp_valid     = ov_ff;
   assign rsp_out_bytes = ob_ff;
   assign rsp_out_count = oc_ff;
   assign rsp_run_last  = ol_ff;
   assign rsp_status    = os_ff;

   always_comb begin
      logic       b, emit, stop, fin_byte, match_go;
      logic [7:0] eb;
      logic [8:0] c;
      logic [3:0] n;
      logic [15:0] d;
      seq_in = seq_ff; phase_in = phase_ff; byte_in = byte_ff; bit_in = bit_ff;
      code_in = code_ff; cnt_in = cnt_ff; need_in = need_ff; extra_in = extra_ff;
      len_in = len_ff; dist_in = dist_ff; wp_in = wp_ff; fill_in = fill_ff;
      stat_in = stat_ff; acc_in = acc_ff; acnt_in = acnt_ff; sent_in = sent_ff;
      ov_in = ov_ff; ob_in = ob_ff; oc_in = oc_ff; ol_in = ol_ff; os_in = os_ff;
      emit = 1'b0; eb = 8'd0; stop = 1'b0; fin_byte = 1'b0; match_go = 1'b0;
      wr_en = 1'b0; wr_data = 8'd0;
      d = (wp_ff >= AW'(dist_ff)) ? 16'(wp_ff - AW'(dist_ff))
                                  : 16'(wp_ff) + 16'(WINDOW_BYTES) - dist_ff;
      rd_addr = d[AW-1:0];
      b = byte_ff[bit_ff[2:0]];
      c = 9'd0; n = 4'd0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_valid && req_ready) begin
               byte_in = req_in_byte; bit_in = 4'd0; acnt_in = 4'd0; acc_in = 64'd0;
               sent_in = 1'b0;
               seq_in = (phase_ff == PH_STOPPED) ? SQ_IDLE : SQ_BIT;
            end
         end
         SQ_BIT: begin
            if (!(ov_ff && !rsp_ready)) begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     c = code_ff | (9'(b) << cnt_ff);
                     code_in = c; cnt_in = cnt_ff + 4'd1;
                     if (cnt_ff == 4'd2) begin
                        code_in = 9'd0; cnt_in = 4'd0;
                        if (c[2:1] != 2'b01) begin
                           stop = 1'b1; stat_in = ST_BAD_TYPE;
                        end else phase_in = PH_LIT;
                     end
                  end
                  PH_LIT: begin
                     c = {code_ff[7:0], b}; n = cnt_ff + 4'd1;
                     code_in = c; cnt_in = n;
                     if ((n == 4'd7 && c <= 9'd23) || n >= 4'd9 ||
                         (n == 4'd8 && c >= 9'(LIT_OFFSET) && c <= 9'd199)) begin
                        code_in = 9'd0; cnt_in = 4'd0;
                        if (n == 4'd8 && c <= 9'd191) begin
                           emit = 1'b1; eb = 8'(c - 9'(LIT_OFFSET));
                        end else if (n == 4'd9) begin
                           emit = 1'b1; eb = c[7:0];
                        end else begin
                           c = (n == 4'd7) ? c + 9'(END_SYMBOL) : c + 9'(LEN_OFFSET);
                           if (c == 9'(END_SYMBOL)) begin
                              stop = 1'b1; stat_in = ST_DONE;
                           end else if (c > 9'(MAX_LEN_SYM)) begin
                              stop = 1'b1; stat_in = ST_BAD_LIT;
                           end else begin
                              len_in = len_base(5'(c - 9'(END_SYMBOL + 1)));
                              need_in = len_extra(5'(c - 9'(END_SYMBOL + 1)));
                              extra_in = 13'd0;
                              phase_in = (need_in == 4'd0) ? PH_DIST : PH_LEN_EXTRA;
                           end
                        end
                     end
                  end
                  PH_LEN_EXTRA: begin
                     extra_in = extra_ff | (13'(b) << cnt_ff);
                     cnt_in = cnt_ff + 4'd1;
                     if (cnt_in >= need_ff) begin
                        len_in = len_ff + extra_in[8:0];
                        code_in = 9'd0; cnt_in = 4'd0; phase_in = PH_DIST;
                     end
                  end
                  PH_DIST: begin
                     c = {4'd0, code_ff[3:0], b}; n = cnt_ff + 4'd1;
                     code_in = c; cnt_in = n;
                     if (n >= 4'd5) begin
                        if (c > 9'(MAX_DIST_CODE)) begin
                           stop = 1'b1; stat_in = ST_BAD_DIST;
                        end else begin
                           dist_in = dist_base(c[4:0]);
                           need_in = dist_extra(c[4:0]);
                           extra_in = 13'd0; cnt_in = 4'd0;
                           if (need_in == 4'd0) match_go = 1'b1;
                           else phase_in = PH_DIST_EXTRA;
                        end
                     end
                  end
                  PH_DIST_EXTRA: begin
                     extra_in = extra_ff | (13'(b) << cnt_ff);
                     cnt_in = cnt_ff + 4'd1;
                     if (cnt_in >= need_ff) begin
                        dist_in = dist_ff + 16'(extra_in);
                        match_go = 1'b1;
                     end
                  end
                  default: ;
               endcase
               if (match_go) begin
                  code_in = 9'd0; cnt_in = 4'd0;
                  if (dist_in > 16'(fill_ff) || dist_in == 16'd0) begin
                     stop = 1'b1; stat_in = ST_TOO_FAR;
                  end else begin
                     phase_in = PH_LIT;
                     seq_in = SQ_READ;
                  end
               end
               if (stop) phase_in = PH_STOPPED;
               bit_in = bit_ff + 4'd1;
               if (!match_go || stop) begin
                  if (stop || bit_ff == 4'd7) fin_byte = 1'b1;
               end
            end
         end
         SQ_READ: begin
            seq_in = SQ_WRITE;
         end
         SQ_WRITE: begin
            if (!(ov_ff && !rsp_ready)) begin
               emit = 1'b1; eb = rd_data;
               len_in = len_ff - 9'd1;
               if (len_ff == 9'd1) begin
                  seq_in = SQ_BIT;
                  if (bit_ff == 4'd8) fin_byte = 1'b1;
               end else seq_in = SQ_READ;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
      if (emit) begin
         wr_en = 1'b1; wr_data = eb;
         wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
         if (fill_ff < (AW+1)'(WINDOW_BYTES)) fill_in = fill_ff + (AW+1)'(1);
         acc_in = acc_ff | (64'(eb) << {acnt_ff[2:0], 3'b000});
         acnt_in = acnt_ff + 4'd1;
      end
      if (fin_byte) seq_in = SQ_IDLE;
      // A match is the only source of more than one byte in an input byte, and
      // nothing but an end-of-block code can follow it within the same byte.
      if ((emit && acnt_in == 4'd8) ||
          (fin_byte && !sent_ff && (acnt_in != 4'd0 || stop))) begin
         ov_in = 1'b1; ob_in = acc_in; oc_in = acnt_in; os_in = stat_in;
         ol_in = fin_byte || (seq_ff == SQ_WRITE && len_ff == 9'd1);
         if (seq_ff == SQ_WRITE && bit_ff == 4'd1 && byte_ff[7:1] == 7'd0) begin
            os_in = ST_DONE;
         end
         sent_in = ol_in;
         if (!fin_byte && acnt_in == 4'd8) begin
            acc_in = 64'd0; acnt_in = 4'd0;
         end
      end
      if (emit && acnt_in == 4'd8 && fin_byte) begin
         acc_in = 64'd0; acnt_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_IDLE; phase_ff <= PH_HEADER; code_ff <= 9'd0; cnt_ff <= 4'd0;
         need_ff <= 4'd0; extra_ff <= 13'd0; len_ff <= 9'd0; dist_ff <= 16'd0;
         wp_ff <= '0; fill_ff <= '0; stat_ff <= ST_RUNNING; ov_ff <= 1'b0;
         acnt_ff <= 4'd0; bit_ff <= 4'd0; sent_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in; phase_ff <= phase_in; code_ff <= code_in; cnt_ff <= cnt_in;
         need_ff <= need_in; extra_ff <= extra_in; len_ff <= len_in; dist_ff <= dist_in;
         wp_ff <= wp_in; fill_ff <= fill_in; stat_ff <= stat_in; ov_ff <= ov_in;
         acnt_ff <= acnt_in; bit_ff <= bit_in; sent_ff <= sent_in;
      end
      byte_ff <= byte_in; acc_ff <= acc_in;
      ob_ff <= ob_in; oc_ff <= oc_in; ol_ff <= ol_in; os_ff <= os_in;
   end
endmodule

// ----- design/fhi_checker.sv -----
// Port checker for the fixed Huffman inflate block, bound to the top level.
// Depends only on the top-level ports.
module fhi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_out_count,
   input logic        rsp_run_last,
   input logic [2:0]  rsp_status
);
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_count <= 4'd8) else $error("count above eight");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd5) else $error("unknown status");
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_count == 4'd8)
      else $error("short beat before end of byte");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("input taken while a beat waits");
endmodule

bind fixed_huffman_inflate_top fhi_checker u_fhi_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_bytes(rsp_out_bytes),
   .rsp_out_count(rsp_out_count), .rsp_run_last(rsp_run_last),
   .rsp_status(rsp_status)
);
